// ===== design/gcg_pkg.sv =====
// Shared types, constants and helper functions for the gamepad change event generator.
`timescale 1ns / 1ps
package gcg_pkg;

  // Default slot count and the compare width for the slot number check
  localparam int SLOTS_DEFAULT = 4;
  localparam int SLOT_CNT_W    = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_TH  = 2'd2;

  localparam logic [15:0] LEFT_DZ_RESET  = 16'd7849;
  localparam logic [15:0] RIGHT_DZ_RESET = 16'd8689;
  localparam logic [7:0]  TRIG_TH_RESET  = 8'd30;

  // Event kinds
  localparam logic [2:0] EV_CONNECT    = 3'd0;
  localparam logic [2:0] EV_DISCONNECT = 3'd1;
  localparam logic [2:0] EV_BTN_DOWN   = 3'd2;
  localparam logic [2:0] EV_BTN_UP     = 3'd3;
  localparam logic [2:0] EV_AXIS       = 3'd4;

  // Pending event vector layout: connect/disconnect, 14 buttons, 6 axes
  localparam int NUM_BTN    = 14;
  localparam int NUM_AXIS   = 6;
  localparam int PEND_CD    = 0;
  localparam int PEND_BTN   = 1;
  localparam int PEND_AXIS  = PEND_BTN + NUM_BTN;
  localparam int PEND_W     = PEND_AXIS + NUM_AXIS;
  localparam int SEL_W      = $clog2(PEND_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         pad_index;
    logic               present;
    logic [31:0]        packet_number;
    logic [15:0]        buttons;
    logic [7:0]         ltrig;
    logic [7:0]         rtrig;
    logic signed [15:0] lstick_x;
    logic signed [15:0] lstick_y;
    logic signed [15:0] rstick_x;
    logic signed [15:0] rstick_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [1:0]         out_pad;
    logic [31:0]        out_packet;
    logic [3:0]         control_code;
    logic signed [15:0] new_value;
    logic signed [15:0] old_value;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] left_dz;
    logic [15:0] right_dz;
    logic [7:0]  trig_th;
  } cfg_t;

  // One queued run of events
  typedef struct packed {
    logic [1:0]                    pad;
    logic [31:0]                   packet;
    logic                          connect;
    logic [PEND_W-1:0]             pending;
    logic [NUM_BTN-1:0]            btn_val;
    logic [NUM_AXIS-1:0][15:0]     axis_new;
    logic [NUM_AXIS-1:0][15:0]     axis_old;
  } job_t;

  // Drop raw bits 10 and 11 from the button word
  function automatic logic [NUM_BTN-1:0] btn_map(input logic [15:0] w);
    btn_map = {w[15:12], w[9:0]};
  endfunction

  function automatic logic [15:0] stick_dz(input logic [15:0] v, input logic [15:0] dz);
    logic [16:0] mag;
    mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    stick_dz = (mag <= {1'b0, dz}) ? 16'd0 : v;
  endfunction

  function automatic logic [15:0] trig_dz(input logic [7:0] v, input logic [7:0] th);
    trig_dz = (v <= th) ? 16'd0 : {8'd0, v};
  endfunction

endpackage

// ===== design/gamepad_change_event_generator_unit.sv =====
// Top level: configuration registers, front end, run queue and back end.
// The first event of a poll passes through the run queue and the back end's work register into the output register.
// Throughput: one event per cycle while out_ready allows; a poll yields 0 to 21 events, and one with none
// is not queued; the front end takes one poll per cycle while the 2-entry run queue has room.
// Reset: all slots disconnected with zero state, dead zones and trigger threshold at defaults;
// the block takes polls in the first cycle after reset.
`timescale 1ns / 1ps
module gamepad_change_event_generator_unit
  import gcg_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_valid;
  job_t q_din;
  job_t q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_dz  <= LEFT_DZ_RESET;
      cfg_r.right_dz <= RIGHT_DZ_RESET;
      cfg_r.trig_th  <= TRIG_TH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DZ:  cfg_r.left_dz  <= cfg_wdata;
        CFG_RIGHT_DZ: cfg_r.right_dz <= cfg_wdata;
        CFG_TRIG_TH:  cfg_r.trig_th  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  gcg_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_din    (q_din),
    .q_full   (q_full)
  );

  gcg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .din     (q_din),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .dout    (q_dout)
  );

  gcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/gcg_front.sv =====
// Front end: slot state, poll classification and event run build-up.
`timescale 1ns / 1ps
module gcg_front
  import gcg_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_push,
  output job_t     q_din,
  input  logic     q_full
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic        conn_r  [SLOTS];
  logic [31:0] pkt_r   [SLOTS];
  logic [15:0] btn_r   [SLOTS];
  logic [15:0] trig_r  [SLOTS];
  logic [63:0] stick_r [SLOTS];

  logic [SLOT_W-1:0] idx;
  logic              accept;
  logic              in_range;
  logic              cur_conn;
  logic              disc_case;
  logic              conn_case;
  logic              chg_case;
  logic              store;
  logic [15:0]       pb;
  logic [15:0]       pt;
  logic [63:0]       ps;
  logic [NUM_AXIS-1:0][15:0] pv;
  logic [NUM_AXIS-1:0][15:0] cv;
  logic [NUM_AXIS-1:0]       axis_diff;
  logic [NUM_BTN-1:0]        btn_diff;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign idx      = SLOT_W'(in_data.pad_index);
  assign in_range = (SLOT_CNT_W'(in_data.pad_index) < SLOT_CNT_W'(SLOTS));
  assign cur_conn = conn_r[idx];

  assign disc_case = !in_data.present && cur_conn;
  assign conn_case = in_data.present && !cur_conn;
  assign chg_case  = in_data.present && cur_conn && (in_data.packet_number != pkt_r[idx]);

  // A newly connected slot compares against an all-zero state
  assign pb = cur_conn ? btn_r[idx]   : 16'd0;
  assign pt = cur_conn ? trig_r[idx]  : 16'd0;
  assign ps = cur_conn ? stick_r[idx] : 64'd0;

  always_comb begin
    pv[0] = trig_dz(pt[7:0], cfg.trig_th);
    pv[1] = trig_dz(pt[15:8], cfg.trig_th);
    pv[2] = stick_dz(ps[15:0], cfg.left_dz);
    pv[3] = stick_dz(ps[31:16], cfg.left_dz);
    pv[4] = stick_dz(ps[47:32], cfg.right_dz);
    pv[5] = stick_dz(ps[63:48], cfg.right_dz);
    cv[0] = trig_dz(in_data.ltrig, cfg.trig_th);
    cv[1] = trig_dz(in_data.rtrig, cfg.trig_th);
    cv[2] = stick_dz(in_data.lstick_x, cfg.left_dz);
    cv[3] = stick_dz(in_data.lstick_y, cfg.left_dz);
    cv[4] = stick_dz(in_data.rstick_x, cfg.right_dz);
    cv[5] = stick_dz(in_data.rstick_y, cfg.right_dz);
    for (int i = 0; i < NUM_AXIS; i++) begin
      axis_diff[i] = (pv[i] != cv[i]);
    end
  end

  assign btn_diff = btn_map(pb ^ in_data.buttons);

  always_comb begin
    q_din           = '0;
    q_din.pad       = in_data.pad_index;
    q_din.packet    = disc_case ? pkt_r[idx] : in_data.packet_number;
    q_din.connect   = conn_case;
    q_din.btn_val   = btn_map(in_data.buttons);
    q_din.axis_new  = cv;
    q_din.axis_old  = pv;
    q_din.pending[PEND_CD] = disc_case || conn_case;
    // Only a new connection or a new packet carries changes
    if (conn_case || chg_case) begin
      q_din.pending[PEND_BTN +: NUM_BTN]   = btn_diff;
      q_din.pending[PEND_AXIS +: NUM_AXIS] = axis_diff;
    end
  end

  // Drop a changed packet that carries no visible difference, but still store it
  assign q_push = accept && in_range && (disc_case || (q_din.pending != '0));
  assign store  = accept && in_range && (conn_case || chg_case);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        conn_r[s]  <= 1'b0;
        pkt_r[s]   <= '0;
        btn_r[s]   <= '0;
        trig_r[s]  <= '0;
        stick_r[s] <= '0;
      end
    end else if (accept && in_range && disc_case) begin
      conn_r[idx]  <= 1'b0;
      pkt_r[idx]   <= '0;
      btn_r[idx]   <= '0;
      trig_r[idx]  <= '0;
      stick_r[idx] <= '0;
    end else if (store) begin
      conn_r[idx]  <= 1'b1;
      pkt_r[idx]   <= in_data.packet_number;
      btn_r[idx]   <= in_data.buttons;
      trig_r[idx]  <= {in_data.rtrig, in_data.ltrig};
      stick_r[idx] <= {in_data.rstick_y, in_data.rstick_x,
                       in_data.lstick_y, in_data.lstick_x};
    end
  end

endmodule

// ===== design/gcg_queue.sv =====
// Short queue of event runs between the front and back ends.
`timescale 1ns / 1ps
module gcg_queue
  import gcg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t dout
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/gcg_back.sv =====
// Back end: walks one event run and emits one event per cycle into the output register, unless stalled.
`timescale 1ns / 1ps
module gcg_back
  import gcg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_dout,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  job_t              work_r;
  logic              work_valid_r, work_valid_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [PEND_W-1:0] onehot;
  logic [SEL_W-1:0]  sel;
  logic [SEL_W-1:0]  bsel;
  logic [SEL_W-1:0]  asel;
  logic              last;
  logic              emit;
  logic              load;

  // Isolate the lowest pending event
  assign onehot = pend_r & (~pend_r + 1'b1);
  assign last   = ((pend_r & ~onehot) == '0);

  always_comb begin
    sel = '0;
    for (int i = 0; i < PEND_W; i++) begin
      if (onehot[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign bsel = sel - SEL_W'(PEND_BTN);
  assign asel = sel - SEL_W'(PEND_AXIS);

  assign emit  = work_valid_r && (!out_valid_r || out_ready);
  assign load  = q_valid && (!work_valid_r || (emit && last));
  assign q_pop = load;

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.out_pad      = work_r.pad;
    out_data_nxt.out_packet   = work_r.packet;
    out_data_nxt.last_of_run  = last;
    if (sel == SEL_W'(PEND_CD)) begin
      out_data_nxt.event_kind = work_r.connect ? EV_CONNECT : EV_DISCONNECT;
    end else if (sel < SEL_W'(PEND_AXIS)) begin
      out_data_nxt.event_kind   = work_r.btn_val[bsel[3:0]] ? EV_BTN_DOWN : EV_BTN_UP;
      out_data_nxt.control_code = bsel[3:0];
    end else begin
      out_data_nxt.event_kind   = EV_AXIS;
      out_data_nxt.control_code = 4'(asel[2:0]);
      out_data_nxt.new_value    = work_r.axis_new[asel[2:0]];
      out_data_nxt.old_value    = work_r.axis_old[asel[2:0]];
    end
  end

  always_comb begin
    work_valid_nxt = work_valid_r;
    pend_nxt       = pend_r;
    if (load) begin
      work_valid_nxt = 1'b1;
      pend_nxt       = q_dout.pending;
    end else if (emit) begin
      work_valid_nxt = !last;
      pend_nxt       = pend_r & ~onehot;
    end
    // Hold a waiting event until taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work_r <= q_dout;
    end
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
